// ----- design/ccu_pkg.sv -----
// ----------------------------------------------------------------------------
// ccu_pkg
// shared types, codes and calendar helpers of the calendar clock
// ----------------------------------------------------------------------------
package ccu_pkg;

  localparam logic [2:0]  DIV_LAST = 3'd4;
  localparam logic [11:0] EPOCH_YEAR = 12'd1970;
  localparam logic [31:0] EPOCH_DAYS = 32'd719162;
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // floor(2^32 / d) for the divider by a constant
  localparam logic [29:0] RCP_7   = 30'd613566756;
  localparam logic [29:0] RCP_24  = 30'd178956970;
  localparam logic [29:0] RCP_60  = 30'd71582788;
  localparam logic [29:0] RCP_100 = 30'd42949672;
  localparam logic [29:0] RCP_400 = 30'd10737418;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_DATE  = 2'd1,
    ACT_TIME  = 2'd2,
    ACT_STAMP = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DSEC,
    OP_DMIN,
    OP_DHOUR,
    OP_DWDAY,
    OP_YEAR,
    OP_MONTH,
    OP_C100,
    OP_C400,
    OP_MUL,
    OP_SUM,
    OP_W7
  } op_t;

  typedef struct packed {
    logic load;
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_done;
    logic month_done;
  } stat_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_second;
    logic [31:0] new_count;
  } in_item_t;

  typedef struct packed {
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;
    logic [31:0] count_out;
  } out_item_t;

  // non-leap month length, month 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] n;
    unique case (m)
      4'd2:                    n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  // non-leap days in the first k months, k 0..12
  function automatic logic [8:0] cum_days(input logic [3:0] k);
    logic [8:0] n;
    unique case (k)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd59;
      4'd3:    n = 9'd90;
      4'd4:    n = 9'd120;
      4'd5:    n = 9'd151;
      4'd6:    n = 9'd181;
      4'd7:    n = 9'd212;
      4'd8:    n = 9'd243;
      4'd9:    n = 9'd273;
      4'd10:   n = 9'd304;
      4'd11:   n = 9'd334;
      default: n = 9'd365;
    endcase
    return n;
  endfunction

  // leap test over the decoded span 1970..2106, where 2100 is the only odd century
  function automatic logic leap_span(input logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != 12'd2100);
  endfunction

endpackage

// ----- design/ccu_if.sv -----
// ----------------------------------------------------------------------------
// ccu_if
// valid/ready channels of the calendar clock
// ----------------------------------------------------------------------------
interface ccu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] new_year;
  logic [3:0]  new_month;
  logic [4:0]  new_day;
  logic [4:0]  new_hour;
  logic [5:0]  new_minute;
  logic [5:0]  new_second;
  logic [31:0] new_count;

  modport source(output valid, action, new_year, new_month, new_day, new_hour,
                 new_minute, new_second, new_count, input ready);
  modport sink(input valid, action, new_year, new_month, new_day, new_hour,
               new_minute, new_second, new_count, output ready);
endinterface

interface ccu_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic [2:0]  weekday_out;
  logic [31:0] count_out;

  modport source(output valid, year_out, month_out, day_out, hour_out, minute_out,
                 second_out, weekday_out, count_out, input ready);
  modport sink(input valid, year_out, month_out, day_out, hour_out, minute_out,
               second_out, weekday_out, count_out, output ready);
endinterface

// ----- design/ccu_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccu_ctrl
// sequencer for decode and encode passes and the result handshake
// ----------------------------------------------------------------------------
module ccu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_action,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ccu_pkg::stat_t stat,
  output ccu_pkg::cmd_t  cmd
);
  import ccu_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DSEC  = 13'b0000000000010,
    S_DMIN  = 13'b0000000000100,
    S_DHOUR = 13'b0000000001000,
    S_DWDAY = 13'b0000000010000,
    S_YEAR  = 13'b0000000100000,
    S_MONTH = 13'b0000001000000,
    S_C100  = 13'b0000010000000,
    S_C400  = 13'b0000100000000,
    S_MUL   = 13'b0001000000000,
    S_SUM   = 13'b0010000000000,
    S_W7    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   capture;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign capture  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_DATE || in_action == ACT_TIME) state_next = S_C100;
          else state_next = S_DSEC;
        end
      end
      S_DSEC:  if (stat.div_done) state_next = S_DMIN;
      S_DMIN:  if (stat.div_done) state_next = S_DHOUR;
      S_DHOUR: if (stat.div_done) state_next = S_DWDAY;
      S_DWDAY: if (stat.div_done) state_next = S_YEAR;
      S_YEAR:  if (stat.year_done) state_next = S_MONTH;
      S_MONTH: if (stat.month_done) state_next = S_DONE;
      S_C100:  if (stat.div_done) state_next = S_C400;
      S_C400:  if (stat.div_done) state_next = S_MUL;
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_W7;
      S_W7:    if (stat.div_done) state_next = S_DONE;
      S_DONE:  if (capture) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load    = accept;
    cmd.capture = capture;
    unique case (state)
      S_DSEC:  cmd.op = OP_DSEC;
      S_DMIN:  cmd.op = OP_DMIN;
      S_DHOUR: cmd.op = OP_DHOUR;
      S_DWDAY: cmd.op = OP_DWDAY;
      S_YEAR:  cmd.op = OP_YEAR;
      S_MONTH: cmd.op = OP_MONTH;
      S_C100:  cmd.op = OP_C100;
      S_C400:  cmd.op = OP_C400;
      S_MUL:   cmd.op = OP_MUL;
      S_SUM:   cmd.op = OP_SUM;
      S_W7:    cmd.op = OP_W7;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (capture) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- design/ccu_dp.sv -----
// ----------------------------------------------------------------------------
// ccu_dp
// clock state, constant divider, calendar walk, encode arithmetic, result register
// ----------------------------------------------------------------------------
module ccu_dp (
  input  logic               clk,
  input  logic               rst,
  input  ccu_pkg::cmd_t      cmd,
  input  ccu_pkg::in_item_t  item,
  output ccu_pkg::stat_t     stat,
  output ccu_pkg::out_item_t res
);
  import ccu_pkg::*;

  // clock state
  logic [31:0] cnt;
  logic [11:0] yr;
  logic [3:0]  mo;
  logic [4:0]  dy;
  logic [4:0]  hr;
  logic [5:0]  mi;
  logic [5:0]  se;
  logic [2:0]  wd;

  // work registers
  logic [31:0] work;
  logic [15:0] days;
  logic [15:0] tot;
  logic [5:0]  q100;
  logic [6:0]  r100;
  logic [3:0]  q400;
  logic [8:0]  r400;
  logic [20:0] pa;
  logic [20:0] pb;
  logic [6:0]  cc;
  logic [3:0]  dq;
  logic [8:0]  mdays;
  logic [20:0] wsum;
  logic [16:0] hms;
  logic [31:0] dmul;

  // divider
  logic [2:0]  dcnt;
  logic [31:0] dvd;
  logic [29:0] mrc;
  logic [8:0]  dsr;
  logic [31:0] quo;
  logic [8:0]  rem;
  logic [9:0]  rem_est;
  logic [61:0] prod;
  logic [31:0] qd;
  logic [31:0] rdiff;
  logic [9:0]  rfix;
  logic        fix;
  logic        div_run;
  logic        div_done;
  logic [31:0] div_a;
  logic [8:0]  div_b;
  logic [29:0] div_m;

  // combinational helpers
  logic [8:0]  ylen;
  logic [4:0]  dim;
  logic [11:0] p;
  logic [12:0] pp;
  logic [3:0]  kk;
  logic [21:0] pb_full;
  logic [31:0] ydays;
  logic [31:0] ddays;
  logic        leap_c;
  logic [6:0]  cc_c;
  logic [3:0]  dq_c;

  always_comb begin
    div_run = 1'b1;
    unique case (cmd.op)
      OP_DSEC:  begin div_a = cnt;                  div_b = 9'd60;  div_m = RCP_60;  end
      OP_DMIN:  begin div_a = work;                 div_b = 9'd60;  div_m = RCP_60;  end
      OP_DHOUR: begin div_a = work;                 div_b = 9'd24;  div_m = RCP_24;  end
      OP_DWDAY: begin div_a = {16'd0, tot} + 32'd4; div_b = 9'd7;   div_m = RCP_7;   end
      OP_C100:  begin div_a = {20'd0, yr};          div_b = 9'd100; div_m = RCP_100; end
      OP_C400:  begin div_a = {20'd0, yr};          div_b = 9'd400; div_m = RCP_400; end
      OP_W7:    begin div_a = {11'd0, wsum};        div_b = 9'd7;   div_m = RCP_7;   end
      default:  begin div_a = '0; div_b = 9'd1; div_m = '0; div_run = 1'b0; end
    endcase
  end

  // estimate by reciprocal, remainder, then one correction step
  assign div_done = (dcnt == DIV_LAST);
  assign prod     = {30'd0, dvd} * {32'd0, mrc};
  assign qd       = quo * {23'd0, dsr};
  assign rdiff    = dvd - qd;
  assign rfix     = rem_est - {1'b0, dsr};
  assign fix      = (rem_est >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (!div_run || div_done) begin
      dcnt <= '0;
    end else begin
      dcnt <= dcnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (dcnt)
      3'd0: begin
        dvd <= div_a;
        dsr <= div_b;
        mrc <= div_m;
      end
      3'd1: quo <= {2'd0, prod[61:32]};
      3'd2: rem_est <= rdiff[9:0];
      3'd3: begin
        quo <= quo + {31'd0, fix};
        rem <= fix ? rfix[8:0] : rem_est[8:0];
      end
      default: ;
    endcase
  end

  // calendar walk
  assign ylen = leap_span(yr) ? 9'd366 : 9'd365;
  assign dim  = month_len(mo) + {4'd0, (mo == 4'd2) && leap_span(yr)};

  assign stat.div_done   = div_done;
  assign stat.year_done  = (days < {7'd0, ylen});
  assign stat.month_done = (mo >= 4'd12) || (days < {11'd0, dim});

  // encode arithmetic
  assign p       = yr - 12'd1;
  assign pp      = {1'b0, yr} + 13'd399;
  assign kk      = (mo == 4'd0) ? 4'd0 : ((mo > 4'd12) ? 4'd12 : mo - 4'd1);
  assign pb_full = {9'd0, pp} * 22'd365;
  assign leap_c  = (yr[1:0] == 2'd0) && ((r100 != 7'd0) || (r400 == 9'd0));
  assign cc_c    = {1'b0, q100} + 7'd4 - {6'd0, r100 == 7'd0};
  assign dq_c    = q400 + 4'd1 - {3'd0, r400 == 9'd0};

  always_comb begin
    if (yr > EPOCH_YEAR) begin
      ydays = {11'd0, pa} + {22'd0, p[11:2]} - {25'd0, cc} + {28'd0, dq}
            + 32'd3 - EPOCH_DAYS;
    end else begin
      ydays = '0;
    end
    ddays = ydays + {23'd0, mdays} + {27'd0, dy} - 32'd1;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DSEC:  if (div_done) work <= quo;
      OP_DMIN:  if (div_done) work <= quo;
      OP_DHOUR: begin
        if (div_done) begin
          days <= quo[15:0];
          tot  <= quo[15:0];
        end
      end
      OP_YEAR:  if (!stat.year_done) days <= days - {7'd0, ylen};
      OP_MONTH: if (!stat.month_done) days <= days - {11'd0, dim};
      OP_C100: begin
        if (div_done) begin
          q100 <= quo[5:0];
          r100 <= rem[6:0];
        end
      end
      OP_C400: begin
        if (div_done) begin
          q400 <= quo[3:0];
          r400 <= rem;
        end
      end
      OP_MUL: begin
        pa    <= 21'({9'd0, p} * 21'd365);
        pb    <= pb_full[20:0];
        cc    <= cc_c;
        dq    <= dq_c;
        mdays <= cum_days(kk) + {8'd0, leap_c && (kk >= 4'd2)};
      end
      OP_SUM: begin
        work <= ddays;
        wsum <= pb + {10'd0, pp[12:2]} - {14'd0, cc} + {17'd0, dq}
              + {12'd0, mdays} + {16'd0, dy};
        hms  <= {12'd0, hr} * {5'd0, SECS_PER_HOUR} + {11'd0, mi} * 17'd60
              + {11'd0, se};
      end
      OP_W7:    dmul <= 32'(work * SECS_PER_DAY);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      yr  <= EPOCH_YEAR;
      mo  <= 4'd1;
      dy  <= 5'd1;
      hr  <= '0;
      mi  <= '0;
      se  <= '0;
      wd  <= 3'd4;
    end else if (cmd.load) begin
      unique case (item.action)
        ACT_TICK: cnt <= cnt + 32'd1;
        ACT_DATE: begin
          yr <= item.new_year;
          mo <= item.new_month;
          dy <= item.new_day;
        end
        ACT_TIME: begin
          hr <= item.new_hour;
          mi <= item.new_minute;
          se <= item.new_second;
        end
        default:  cnt <= item.new_count;
      endcase
    end else begin
      case (cmd.op)
        OP_DSEC:  if (div_done) se <= rem[5:0];
        OP_DMIN:  if (div_done) mi <= rem[5:0];
        OP_DHOUR: if (div_done) hr <= rem[4:0];
        OP_DWDAY: begin
          if (div_done) begin
            wd <= rem[2:0];
            yr <= EPOCH_YEAR;
            mo <= 4'd1;
          end
        end
        OP_YEAR:  if (!stat.year_done) yr <= yr + 12'd1;
        OP_MONTH: begin
          if (stat.month_done) dy <= days[4:0] + 5'd1;
          else mo <= mo + 4'd1;
        end
        OP_W7: begin
          if (div_done) begin
            wd  <= rem[2:0];
            cnt <= dmul + {15'd0, hms};
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res.year_out    <= yr;
      res.month_out   <= mo;
      res.day_out     <= dy;
      res.hour_out    <= hr;
      res.minute_out  <= mi;
      res.second_out  <= se;
      res.weekday_out <= wd;
      res.count_out   <= cnt;
    end
  end

endmodule

// ----- design/calendar_clock_with_unix_seconds.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_with_unix_seconds
// real-time clock with a 32-bit seconds count, calendar fields and weekday
// ----------------------------------------------------------------------------
// in_ch takes one item per action: tick, set date, set time or set timestamp.
// out_ch returns one item per action with every field after the action.
// one item at a time: in_ch.ready is high only while the sequencer is idle.
// tick and set timestamp: four divider passes, then a walk over the years from
// 1970 and a walk over the months of the year that it reaches.
// set date and set time: two divider passes, the encode multiply and sum and a
// third divider pass.
// the next item can be taken in the cycle after the result is registered.
// all passes share one divider by a constant (reciprocal multiply, remainder,
// one correction step).
// the result sits in an output register; a stalled receiver holds the
// sequencer in its last state until the register is free, so nothing is lost.
// reset gives 1970-01-01 00:00:00, Thursday, count zero, no item pending.
// ----------------------------------------------------------------------------
module calendar_clock_with_unix_seconds (
  input logic       clk,
  input logic       rst,
  ccu_in_if.sink    in_ch,
  ccu_out_if.source out_ch
);
  import ccu_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  in_item_t  item;
  out_item_t res;

  assign item.action     = in_ch.action;
  assign item.new_year   = in_ch.new_year;
  assign item.new_month  = in_ch.new_month;
  assign item.new_day    = in_ch.new_day;
  assign item.new_hour   = in_ch.new_hour;
  assign item.new_minute = in_ch.new_minute;
  assign item.new_second = in_ch.new_second;
  assign item.new_count  = in_ch.new_count;

  ccu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccu_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .item (item),
    .stat (stat),
    .res  (res)
  );

  assign out_ch.year_out    = res.year_out;
  assign out_ch.month_out   = res.month_out;
  assign out_ch.day_out     = res.day_out;
  assign out_ch.hour_out    = res.hour_out;
  assign out_ch.minute_out  = res.minute_out;
  assign out_ch.second_out  = res.second_out;
  assign out_ch.weekday_out = res.weekday_out;
  assign out_ch.count_out   = res.count_out;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.weekday_out != 3'd7)
    else $error("weekday out of range");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result shown straight after reset");

endmodule

// ----- test/calendar_clock_with_unix_seconds_check.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_with_unix_seconds_check
// watches both channels, works out the clock state after every accepted
// item and compares each returned item field by field with the oldest one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_clock_with_unix_seconds_check (
  input  logic clk,
  input  logic rst,
  ccu_in_if    in_ch,
  ccu_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import ccu_pkg::*;

  out_item_t clock_state;
  out_item_t expected_times[$];

  function automatic bit greg_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned n;
    n = lens[(m - 1) % 12];
    if (m == 2 && greg_leap(y)) n++;
    return n;
  endfunction

  function automatic longint unsigned days_to_year(longint unsigned y);
    longint unsigned p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic int unsigned days_to_month(int unsigned y, int unsigned m);
    int unsigned sum;
    sum = 0;
    for (int unsigned k = 1; k < m && k <= 12; k++) sum += month_days(y, k);
    return sum;
  endfunction

  function automatic out_item_t decode_count(out_item_t s, logic [31:0] cnt);
    int unsigned t, days, total, y, m;
    t = cnt;
    s.count_out = cnt;
    s.second_out = 6'(t % 60);
    t = t / 60;
    s.minute_out = 6'(t % 60);
    t = t / 60;
    s.hour_out = 5'(t % 24);
    days = t / 24;
    total = days;
    y = 1970;
    while (days >= 365 + greg_leap(y)) begin
      days -= 365 + greg_leap(y);
      y++;
    end
    m = 1;
    while (m < 12 && days >= month_days(y, m)) begin
      days -= month_days(y, m);
      m++;
    end
    s.year_out = 12'(y);
    s.month_out = 4'(m);
    s.day_out = 5'(days + 1);
    s.weekday_out = 3'((longint'(total) + 4) % 7);
    return s;
  endfunction

  function automatic out_item_t encode_fields(out_item_t s);
    longint unsigned ydays, days, secs;
    int unsigned mdays;
    ydays = 0;
    mdays = days_to_month(s.year_out, s.month_out);
    if (s.year_out > 1970) ydays = days_to_year(s.year_out) - days_to_year(1970);
    days = (ydays + mdays + s.day_out - 1) & 64'hFFFF_FFFF;
    secs = days * 86400 + longint'(s.hour_out) * 3600 + longint'(s.minute_out) * 60
         + s.second_out;
    s.count_out = secs[31:0];
    s.weekday_out = 3'((days_to_year(longint'(s.year_out) + 400) + mdays + s.day_out) % 7);
    return s;
  endfunction

  function automatic out_item_t advance_clock(out_item_t s, in_item_t it);
    case (action_t'(it.action))
      ACT_TICK: s = decode_count(s, s.count_out + 32'd1);
      ACT_DATE: begin
        s.year_out = it.new_year;
        s.month_out = it.new_month;
        s.day_out = it.new_day;
        s = encode_fields(s);
      end
      ACT_TIME: begin
        s.hour_out = it.new_hour;
        s.minute_out = it.new_minute;
        s.second_out = it.new_second;
        s = encode_fields(s);
      end
      default: s = decode_count(s, it.new_count);
    endcase
    return s;
  endfunction

  assign pending = expected_times.size();

  always @(posedge clk) begin
    in_item_t it;
    out_item_t want;
    if (rst) begin
      clock_state <= '{year_out: 12'd1970, month_out: 4'd1, day_out: 5'd1,
                       weekday_out: 3'd4, default: '0};
      expected_times.delete();
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it = '{in_ch.action, in_ch.new_year, in_ch.new_month, in_ch.new_day,
               in_ch.new_hour, in_ch.new_minute, in_ch.new_second, in_ch.new_count};
        want = advance_clock(clock_state, it);
        clock_state <= want;
        expected_times.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_times.size() == 0) begin
          $error("result item with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_times.pop_front();
          if (out_ch.year_out !== want.year_out ||
              out_ch.month_out !== want.month_out ||
              out_ch.day_out !== want.day_out ||
              out_ch.hour_out !== want.hour_out ||
              out_ch.minute_out !== want.minute_out ||
              out_ch.second_out !== want.second_out ||
              out_ch.weekday_out !== want.weekday_out ||
              out_ch.count_out !== want.count_out)
            fail_count <= fail_count + 1;
          if (out_ch.year_out !== want.year_out)
            $error("year_out expected %0d got %0d", want.year_out, out_ch.year_out);
          if (out_ch.month_out !== want.month_out)
            $error("month_out expected %0d got %0d", want.month_out, out_ch.month_out);
          if (out_ch.day_out !== want.day_out)
            $error("day_out expected %0d got %0d", want.day_out, out_ch.day_out);
          if (out_ch.hour_out !== want.hour_out)
            $error("hour_out expected %0d got %0d", want.hour_out, out_ch.hour_out);
          if (out_ch.minute_out !== want.minute_out)
            $error("minute_out expected %0d got %0d", want.minute_out, out_ch.minute_out);
          if (out_ch.second_out !== want.second_out)
            $error("second_out expected %0d got %0d", want.second_out, out_ch.second_out);
          if (out_ch.weekday_out !== want.weekday_out)
            $error("weekday_out expected %0d got %0d", want.weekday_out,
                   out_ch.weekday_out);
          if (out_ch.count_out !== want.count_out)
            $error("count_out expected %0h got %0h", want.count_out, out_ch.count_out);
        end
      end
    end
  end

endmodule

// ----- test/calendar_clock_with_unix_seconds_test.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_with_unix_seconds_test
// drives ticks, date, time and timestamp writes in random bursts against a
// stalling receiver; the checker beside the block predicts every item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_clock_with_unix_seconds_test;
  import ccu_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 930;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   burst_left = 0;

  ccu_in_if  in_ch();
  ccu_out_if out_ch();

  calendar_clock_with_unix_seconds u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  calendar_clock_with_unix_seconds_check u_check (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycles == 3000) hold = 1500;
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else if (cycles % 4000 < 1500) out_ch.ready = 1'b1;
      else out_ch.ready = ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 300)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    {in_ch.action, in_ch.new_year, in_ch.new_month, in_ch.new_day, in_ch.new_hour,
     in_ch.new_minute, in_ch.new_second, in_ch.new_count} = it;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  function automatic in_item_t make_item(action_t a, int y, int mo, int d, int h,
                                         int mi, int s, logic [31:0] c);
    in_item_t it;
    it = '{a, 12'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s), c};
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.action = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) != 0) begin
      it.new_year = 12'($urandom_range(1970, 2105));
      it.new_month = 4'($urandom_range(1, 12));
      it.new_day = 5'($urandom_range(1, 28));
      it.new_hour = 5'($urandom_range(0, 23));
      it.new_minute = 6'($urandom_range(0, 59));
      it.new_second = 6'($urandom_range(0, 59));
    end
    if ($urandom_range(0, 3) == 0) it.new_count = $urandom_range(0, 86400 * 800);
    if (it.action == ACT_TICK && $urandom_range(0, 1) == 0) begin
      it.action = ACT_TIME;
      it.new_hour = 5'd23;
      it.new_minute = 6'd59;
      it.new_second = 6'($urandom_range(57, 59));
    end
    return it;
  endfunction

  initial begin
    in_item_t directed[$];
    in_ch.valid = 1'b0;
    {in_ch.action, in_ch.new_year, in_ch.new_month, in_ch.new_day, in_ch.new_hour,
     in_ch.new_minute, in_ch.new_second, in_ch.new_count} = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_STAMP, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_STAMP, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFE));
    directed.push_back(make_item(ACT_DATE, 2105, 12, 31, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_DATE, 2100, 2, 28, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_TIME, 0, 0, 0, 23, 59, 59, 0));
    directed.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_DATE, 2000, 2, 29, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_TIME, 0, 0, 0, 23, 59, 59, 0));
    directed.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_DATE, 1970, 1, 1, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_DATE, 1969, 5, 3, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_DATE, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_DATE, 2024, 13, 31, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_DATE, 4095, 15, 31, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_TIME, 0, 0, 0, 31, 63, 63, 0));
    directed.push_back(make_item(ACT_DATE, 2106, 2, 7, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_TIME, 0, 0, 0, 6, 28, 15, 0));
    directed.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(ACT_STAMP, 0, 0, 0, 0, 0, 0, 32'd951782399));
    directed.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_item(directed[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) send_item(random_item());
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ccu_pkg.sv
design/ccu_if.sv
design/ccu_ctrl.sv
design/ccu_dp.sv
design/calendar_clock_with_unix_seconds.sv
test/calendar_clock_with_unix_seconds_check.sv
test/calendar_clock_with_unix_seconds_test.sv
